// File: sv/bd_pkg.sv
package bd_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int GUARD_BITS   = 24;
  localparam int COORD_W      = 32;
  localparam int DIFF_W       = COORD_W + 1;
  // Pre-rotated vector is below 2^57 in magnitude; CORDIC gain adds under 2 bits.
  localparam int CW           = 60;
  localparam int ANG_W        = 32;
  localparam int DIST_W       = 33;
  localparam int BEAR_W       = 16;
  localparam int HI_W         = CW - 32;
  localparam int SUM_W        = HI_W + 33;

  localparam logic [31:0] INV_GAIN = 32'd2608131496;
  localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic [ANG_W-1:0] ROUND_HALF = 32'h0000_8000;

  // atan(2^-i) in 32-bit turns
  localparam logic [ANG_W-1:0] ANG_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic                 zero;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [ANG_W-1:0]     z;
  } cordic_t;

endpackage

// File: sv/bearing_and_distance.sv
// channel | signals                                   | beat carries
// --------+-------------------------------------------+--------------------------------
// in      | in_valid, in_ready                        | origin_x/y, target_x/y (Q16.16)
// out     | out_valid, out_ready                      | distance (Q17.16), bearing
//
// One beat enters per cycle while the output is not held; the stages are:
// one stage for the difference and pre-rotation, one per micro-rotation, one for
// the gain-correction products, one for the final sum in the output register.
// rst is synchronous and clears only the stage valid bits.
// A held output freezes the whole pipeline; in_ready drops only while a result
// waits, so no beat is lost or repeated.
module bearing_and_distance (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [bd_pkg::COORD_W-1:0] origin_x,
  input  logic signed [bd_pkg::COORD_W-1:0] origin_y,
  input  logic signed [bd_pkg::COORD_W-1:0] target_x,
  input  logic signed [bd_pkg::COORD_W-1:0] target_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bd_pkg::DIST_W-1:0]        distance,
  output logic [bd_pkg::BEAR_W-1:0]        bearing
);
  import bd_pkg::*;

  logic en;

  // Front stage: difference vector, guard scaling, half-turn pre-rotation
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [CW-1:0]     gx;
  logic signed [CW-1:0]     gy;
  cordic_t                  pre_next;
  logic                     s0_vld;
  cordic_t                  s0;

  // CORDIC outputs
  logic    c_vld;
  cordic_t c_data;

  // Gain-correction stage
  logic [CW-1:0]      ux;
  logic               m_vld;
  logic               m_zero;
  logic [CW-1:0]      m_hi;
  logic [31:0]        m_lo;
  logic [BEAR_W-1:0]  m_bear;
  logic [ANG_W-1:0]   z_round;
  logic [2*32-1:0]    lo_prod;
  logic [SUM_W-1:0]   dist_sum;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign dx = DIFF_W'(target_x) - DIFF_W'(origin_x);
  assign dy = DIFF_W'(target_y) - DIFF_W'(origin_y);
  assign gx = {{(CW-DIFF_W-GUARD_BITS){dx[DIFF_W-1]}}, dx, {GUARD_BITS{1'b0}}};
  assign gy = {{(CW-DIFF_W-GUARD_BITS){dy[DIFF_W-1]}}, dy, {GUARD_BITS{1'b0}}};

  always_comb begin
    pre_next.zero = (dx == '0) && (dy == '0);
    // north is the rotation x-axis, east the y-axis
    if (dy[DIFF_W-1]) begin
      pre_next.x = -gy;
      pre_next.y = -gx;
      pre_next.z = HALF_TURN;
    end else begin
      pre_next.x = gy;
      pre_next.y = gx;
      pre_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= pre_next;
    end
  end

  bd_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s0_vld),
    .in_data  (s0),
    .out_vld  (c_vld),
    .out_data (c_data)
  );

  assign ux      = c_data.x[CW-1] ? '0 : c_data.x;
  assign lo_prod = 64'(ux[31:0]) * 64'(INV_GAIN);
  assign z_round = c_data.z + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else if (en) begin
      m_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_zero <= c_data.zero;
      m_hi   <= CW'(ux[CW-1:32] * INV_GAIN);
      m_lo   <= lo_prod[63:32];
      m_bear <= z_round[ANG_W-1:ANG_W-BEAR_W];
    end
  end

  assign dist_sum = SUM_W'(m_hi) + SUM_W'(m_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (m_zero) begin
        distance <= '0;
        bearing  <= '0;
      end else begin
        distance <= dist_sum[GUARD_BITS+DIST_W-1:GUARD_BITS];
        bearing  <= m_bear;
      end
    end
  end

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output register");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s0_vld)
    else $error("accepted beat missing from front stage");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(s0_vld) && $stable(c_vld) && $stable(m_vld))
    else $error("pipeline valid bits moved during stall");

  a_coincident_zero: assert property (@(posedge clk) disable iff (rst)
    m_vld && m_zero && en |=> distance == '0 && bearing == '0)
    else $error("coincident points gave nonzero result");
`endif

endmodule

// File: sv/bd_cordic.sv
module bd_cordic (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  bd_pkg::cordic_t in_data,
  output logic            out_vld,
  output bd_pkg::cordic_t out_data
);
  import bd_pkg::*;

  logic [CORDIC_STEPS:1] vld;
  cordic_t               st [1:CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cordic_t              cur;
    cordic_t              nxt;
    logic                 cur_vld;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;

    if (i == 0) begin : g_first
      assign cur     = in_data;
      assign cur_vld = in_vld;
    end else begin : g_rest
      assign cur     = st[i];
      assign cur_vld = vld[i];
    end

    assign sx = cur.x >>> i;
    assign sy = cur.y >>> i;

    always_comb begin
      nxt.zero = cur.zero;
      if (!cur.y[CW-1]) begin
        nxt.x = cur.x + sy;
        nxt.y = cur.y - sx;
        nxt.z = cur.z + ANG_TAB[i];
      end else begin
        nxt.x = cur.x - sy;
        nxt.y = cur.y + sx;
        nxt.z = cur.z - ANG_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  assign out_vld  = vld[CORDIC_STEPS];
  assign out_data = st[CORDIC_STEPS];

endmodule
